[sv/vtr_pkg.sv]
package vtr_pkg;

  localparam int unsigned POS_W     = 15;
  localparam int unsigned CAP_W     = 15;
  localparam int unsigned TYPE_W    = 16;
  localparam int unsigned MAX_BURST = 6;
  localparam int unsigned QDEPTH    = MAX_BURST + 1;
  localparam int unsigned CNT_W     = $clog2(QDEPTH + 1);

  localparam logic [POS_W-1:0] TYPE_OFFSET    = 15'd12;
  localparam logic [POS_W-1:0] TYPE_OFFSET_LO = 15'd13;
  localparam logic [POS_W-1:0] POS_MAX        = 15'h7fff;
  localparam logic [POS_W:0]   HEADER_LEN     = 16'd14;
  localparam logic [POS_W:0]   TAGGED_MIN_LEN = 16'd18;
  localparam logic [POS_W+1:0] TAG_LEN        = 17'd4;

  localparam logic [CAP_W-1:0]  CAP_RESET       = 15'd9216;
  localparam logic [TYPE_W-1:0] VLAN_TYPE_RESET = 16'h8100;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NO_ROOM   = 2'd2
  } status_e;

  typedef enum logic {
    REG_CAPACITY  = 1'b0,
    REG_VLAN_TYPE = 1'b1
  } reg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_e    status;
  } word_t;

endpackage

[sv/vtr_in_if.sv]
interface vtr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        end_of_frame;
  logic        tag_present;
  logic [15:0] tag_control;
  logic [15:0] tag_protocol;

  modport source (
    output valid, data_byte, end_of_frame, tag_present, tag_control, tag_protocol,
    input  ready
  );
  modport sink (
    input  valid, data_byte, end_of_frame, tag_present, tag_control, tag_protocol,
    output ready
  );
endinterface

[sv/vtr_out_if.sv]
interface vtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] frame_status;

  modport source (
    output valid, out_byte, out_last, frame_status,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_last, frame_status,
    output ready
  );
endinterface

[sv/vlan_tag_reinsert_stream_top.sv]
// Accepted words are registered into the output queue; the first outer type byte is held.
// Input words are taken one per cycle while the output queue holds at most one word;
// the outer type byte pair of a frame loads two output words, or six when the tag is inserted.
// Output words drain one per cycle, while out_o.ready is high, from a seven-entry output queue.
// Reset (rst_ni low, async): frame state cleared, queue emptied, capacity 9216, VLAN type 0x8100.
module vlan_tag_reinsert_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vtr_in_if.sink      in_i,
  vtr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vtr_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [TYPE_W-1:0] vtype_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       held_q, held_d;
  logic             has_tag_q, has_tag_d;
  logic [15:0]      tci_q, tci_d;
  logic [15:0]      tpid_q, tpid_d;
  logic             ins_q, ins_d;
  logic             alr_q, alr_d;

  word_t            q_q [QDEPTH];
  word_t            q_d [QDEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  word_t            new_w [MAX_BURST];
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] base;
  logic             push, pop, cfg_wr;
  logic             first, at_hi, at_lo, do_insert;
  logic             cur_tag;
  logic [15:0]      cur_tci, cur_tpid;
  logic             cur_ins, cur_alr;
  logic [15:0]      outer;
  logic [POS_W:0]   len;
  logic [POS_W+1:0] len_tag;
  status_e          status;
  reg_e             reg_sel;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_CAPACITY:  prdata = {17'd0, cap_q};
      REG_VLAN_TYPE: prdata = {16'd0, vtype_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      vtype_q <= VLAN_TYPE_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CAPACITY:  cap_q   <= pwdata[CAP_W-1:0];
        REG_VLAN_TYPE: vtype_q <= pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_i.ready = (cnt_q <= CNT_W'(1));
  assign push       = in_i.valid & in_i.ready;
  assign out_o.valid = (cnt_q != '0);
  assign pop        = out_o.valid & out_o.ready;

  assign out_o.out_byte     = q_q[0].data;
  assign out_o.out_last     = q_q[0].last;
  assign out_o.frame_status = q_q[0].status;

  // per-word frame logic
  always_comb begin
    first     = (pos_q == '0);
    at_hi     = (pos_q == TYPE_OFFSET);
    at_lo     = (pos_q == TYPE_OFFSET_LO);
    cur_tag   = first ? in_i.tag_present  : has_tag_q;
    cur_tci   = first ? in_i.tag_control  : tci_q;
    cur_tpid  = first ? in_i.tag_protocol : tpid_q;
    outer     = {held_q, in_i.data_byte};
    do_insert = at_lo & cur_tag & (outer != vtype_q);
    cur_ins   = ~first & ins_q | do_insert;
    cur_alr   = at_lo ? (cur_tag & ~do_insert) : (~first & alr_q);

    len     = {1'b0, pos_q} + 16'd1;
    len_tag = {1'b0, len} + TAG_LEN;
    if (len > {1'b0, cap_q})                     status = ST_NO_ROOM;
    else if (!cur_tag)                           status = ST_OK;
    else if (len < HEADER_LEN)                   status = ST_MALFORMED;
    else if (cur_alr)                            status = (len < TAGGED_MIN_LEN) ? ST_MALFORMED
                                                                                 : ST_OK;
    else if (cur_ins && (len_tag > {2'b0, cap_q})) status = ST_NO_ROOM;
    else                                         status = ST_OK;

    for (int k = 0; k < MAX_BURST; k++) begin
      new_w[k] = '{data: in_i.data_byte, last: 1'b0, status: ST_OK};
    end
    if (at_hi) begin
      n_new = in_i.end_of_frame ? CNT_W'(1) : CNT_W'(0);
    end else if (do_insert) begin
      n_new         = CNT_W'(6);
      new_w[0].data = cur_tpid[15:8];
      new_w[1].data = cur_tpid[7:0];
      new_w[2].data = cur_tci[15:8];
      new_w[3].data = cur_tci[7:0];
      new_w[4].data = held_q;
    end else if (at_lo) begin
      n_new         = CNT_W'(2);
      new_w[0].data = held_q;
    end else begin
      n_new = CNT_W'(1);
    end

    last_idx = n_new - CNT_W'(1);
    for (int k = 0; k < MAX_BURST; k++) begin
      if (in_i.end_of_frame && (last_idx == CNT_W'(k))) begin
        new_w[k].last   = 1'b1;
        new_w[k].status = status;
      end
    end
  end

  // output queue
  always_comb begin
    base = cnt_q - {{(CNT_W-1){1'b0}}, pop};
    for (int j = 0; j < QDEPTH; j++) begin
      q_d[j] = (pop && (j < QDEPTH - 1)) ? q_q[(j + 1) % QDEPTH] : q_q[j];
    end
    if (push) begin
      for (int k = 0; k < MAX_BURST; k++) begin
        if (CNT_W'(k) < n_new) begin
          if (base[0]) q_d[k + 1] = new_w[k];
          else         q_d[k]     = new_w[k];
        end
      end
    end
    cnt_d = base + (push ? n_new : CNT_W'(0));
  end

  // frame state next
  always_comb begin
    pos_d     = pos_q;
    held_d    = held_q;
    has_tag_d = has_tag_q;
    tci_d     = tci_q;
    tpid_d    = tpid_q;
    ins_d     = ins_q;
    alr_d     = alr_q;
    if (push) begin
      has_tag_d = cur_tag;
      tci_d     = cur_tci;
      tpid_d    = cur_tpid;
      ins_d     = cur_ins;
      alr_d     = cur_alr;
      if (at_hi) held_d = in_i.data_byte;
      if (in_i.end_of_frame)  pos_d = '0;
      else if (pos_q < POS_MAX) pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      held_q    <= '0;
      has_tag_q <= 1'b0;
      tci_q     <= '0;
      tpid_q    <= '0;
      ins_q     <= 1'b0;
      alr_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      held_q    <= held_d;
      has_tag_q <= has_tag_d;
      tci_q     <= tci_d;
      tpid_q    <= tpid_d;
      ins_q     <= ins_d;
      alr_q     <= alr_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QDEPTH; j++) begin
      q_q[j] <= q_d[j];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH))
    else $error("output queue overflow");

  a_hold_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && at_hi && !in_i.end_of_frame && !pop |=> cnt_q == $past(cnt_q))
    else $error("held type byte produced output");

  a_eof_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && in_i.end_of_frame |=> pos_q == '0)
    else $error("position not cleared after frame end");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_last |-> out_o.frame_status == ST_OK)
    else $error("status on non-final word");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && do_insert |=> cnt_q >= CNT_W'(MAX_BURST))
    else $error("tag burst not queued");

endmodule
